@@ rtl/iaid_pkg.sv @@
// ----------------------------------------------------------------------------
// iaid_pkg
// Shared types and codes for the indexed array insert/delete core.
// ----------------------------------------------------------------------------
package iaid_pkg;

    localparam int unsigned POS_W   = 7;   // request position field
    localparam int unsigned IPOS_W  = 6;   // reported element index
    localparam int unsigned CNT_W   = 7;   // reported count
    localparam int unsigned DATA_W  = 32;

    // operation codes
    localparam logic [1:0] OP_INSERT   = 2'd0;
    localparam logic [1:0] OP_DELETE   = 2'd1;
    localparam logic [1:0] OP_TRAVERSE = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_BADIDX = 2'd1;
    localparam logic [1:0] ST_EMPTY  = 2'd2;
    localparam logic [1:0] ST_FULL   = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INS_RD,
        S_INS_WR,
        S_INS_PUT,
        S_DEL_RD0,
        S_DEL_CAP,
        S_DEL_RD,
        S_DEL_WR,
        S_TRV_RD,
        S_TRV_PUT,
        S_REPLY
    } t_state;

    typedef struct packed {
        logic [1:0]               status;
        logic signed [DATA_W-1:0] value;
        logic [IPOS_W-1:0]        position;
        logic [CNT_W-1:0]         count;
        logic                     last;
    } t_result;

endpackage

@@ rtl/indexed_array_insert_delete_core.sv @@
// ----------------------------------------------------------------------------
// indexed_array_insert_delete_core
// Packed array of signed 32-bit elements with insert, delete and traverse.
// ----------------------------------------------------------------------------
// Request channel (i_valid/o_ready): i_op, i_position, i_new_value. A transfer
// takes place when both are high; o_ready is high only while no request is
// in progress.
// Result channel (o_valid/i_ready): o_status, o_item_value, o_item_position,
// o_new_count, o_last. Insert, delete and any failed request give one result
// with o_last set; a traverse gives one result per stored element, o_last on
// the final one.
// Steps: each element moved by an insert or delete takes a read then a write
// through the single memory port pair. A delete first reads and captures the
// removed element; a failed request goes straight to its reply. A traverse
// reads each element, then hands it on as a result. Each result passes
// through the output register before it shows on o_valid.
// Results go through an output register; a stalled receiver holds that
// register and the sequencer waits, with nothing lost.
// Reset (synchronous, active low) empties the array: count goes to zero.
// The element memory itself is not cleared; only written entries are read.
// ----------------------------------------------------------------------------
module indexed_array_insert_delete_core #(
    parameter int unsigned CAPACITY = 64
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // request channel
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic [1:0]                         i_op,
    input  logic [iaid_pkg::POS_W-1:0]         i_position,
    input  logic signed [iaid_pkg::DATA_W-1:0] i_new_value,
    // result channel
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic [1:0]                         o_status,
    output logic signed [iaid_pkg::DATA_W-1:0] o_item_value,
    output logic [iaid_pkg::IPOS_W-1:0]        o_item_position,
    output logic [iaid_pkg::CNT_W-1:0]         o_new_count,
    output logic                               o_last
);

    localparam int unsigned AW = $clog2(CAPACITY);
    localparam int unsigned CW = $clog2(CAPACITY + 1);

    // sequencer <-> output register
    logic              res_valid;
    logic              res_ready;
    iaid_pkg::t_result res;

    // sequencer <-> memory
    logic                        mem_we;
    logic [AW-1:0]               mem_waddr;
    logic [iaid_pkg::DATA_W-1:0] mem_wdata;
    logic                        mem_re;
    logic [AW-1:0]               mem_raddr;
    logic [iaid_pkg::DATA_W-1:0] mem_rdata;

    // output register
    logic              r_out_valid;
    iaid_pkg::t_result r_out;

    iaid_ctrl #(
        .CAPACITY (CAPACITY),
        .AW       (AW),
        .CW       (CW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_op        (i_op),
        .i_position  (i_position),
        .i_new_value (i_new_value),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res),
        .o_we        (mem_we),
        .o_waddr     (mem_waddr),
        .o_wdata     (mem_wdata),
        .o_re        (mem_re),
        .o_raddr     (mem_raddr),
        .i_rdata     (mem_rdata)
    );

    iaid_store #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // load when empty or when the held result transfers this cycle
    assign res_ready = !r_out_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) begin
            r_out <= res;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_status        = r_out.status;
    assign o_item_value    = r_out.value;
    assign o_item_position = r_out.position;
    assign o_new_count     = r_out.count;
    assign o_last          = r_out.last;

endmodule

@@ rtl/iaid_store.sv @@
// ----------------------------------------------------------------------------
// iaid_store
// Element memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module iaid_store #(
    parameter int unsigned DEPTH = 64,
    parameter int unsigned AW    = $clog2(DEPTH)
) (
    input  logic                         i_clk,
    input  logic                         i_we,
    input  logic [AW-1:0]                i_waddr,
    input  logic [iaid_pkg::DATA_W-1:0]  i_wdata,
    input  logic                         i_re,
    input  logic [AW-1:0]                i_raddr,
    output logic [iaid_pkg::DATA_W-1:0]  o_rdata
);

    logic [iaid_pkg::DATA_W-1:0] r_mem [DEPTH];
    logic [iaid_pkg::DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/iaid_ctrl.sv @@
// ----------------------------------------------------------------------------
// iaid_ctrl
// Request sequencer: checks a request, then walks the memory one element
// at a time (a read/write pair per moved element) with a single index counter.
// ----------------------------------------------------------------------------
module iaid_ctrl #(
    parameter int unsigned CAPACITY = 64,
    parameter int unsigned AW       = $clog2(CAPACITY),
    parameter int unsigned CW       = $clog2(CAPACITY + 1)
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // request
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic [1:0]                         i_op,
    input  logic [iaid_pkg::POS_W-1:0]         i_position,
    input  logic signed [iaid_pkg::DATA_W-1:0] i_new_value,
    // result toward output register
    output logic                               o_res_valid,
    input  logic                               i_res_ready,
    output iaid_pkg::t_result                  o_res,
    // memory
    output logic                               o_we,
    output logic [AW-1:0]                      o_waddr,
    output logic [iaid_pkg::DATA_W-1:0]        o_wdata,
    output logic                               o_re,
    output logic [AW-1:0]                      o_raddr,
    input  logic [iaid_pkg::DATA_W-1:0]        i_rdata
);

    localparam int unsigned XW = (CW > iaid_pkg::POS_W) ? CW : iaid_pkg::POS_W;

    iaid_pkg::t_state            r_state, n_state;
    logic [CW-1:0]               r_count, n_count;
    logic [CW-1:0]               r_idx,   n_idx;
    logic [AW-1:0]               r_pos,   n_pos;
    logic [iaid_pkg::DATA_W-1:0] r_val,   n_val;
    iaid_pkg::t_result           r_res,   n_res;

    logic [XW-1:0] pos_x, cnt_x, cap_x, idx_x;
    logic [CW-1:0] idx_m1, idx_p1, idx_p2;
    logic          accept;

    assign pos_x  = XW'(i_position);
    assign cnt_x  = XW'(r_count);
    assign cap_x  = XW'(CAPACITY);
    assign idx_x  = XW'(r_idx);
    assign idx_m1 = r_idx - CW'(1);
    assign idx_p1 = r_idx + CW'(1);
    assign idx_p2 = r_idx + CW'(2);
    assign accept = i_valid && o_ready;

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_idx       = r_idx;
        n_pos       = r_pos;
        n_val       = r_val;
        n_res       = r_res;
        o_ready     = 1'b0;
        o_res_valid = 1'b0;
        o_res       = r_res;
        o_we        = 1'b0;
        o_waddr     = r_idx[AW-1:0];
        o_wdata     = i_rdata;
        o_re        = 1'b0;
        o_raddr     = r_idx[AW-1:0];

        case (r_state)
            iaid_pkg::S_IDLE: begin
                o_ready = 1'b1;
                // failure result by default; overwritten on success
                n_res.status   = iaid_pkg::ST_BADIDX;
                n_res.value    = '0;
                n_res.position = '0;
                n_res.count    = cnt_x[iaid_pkg::CNT_W-1:0];
                n_res.last     = 1'b1;
                if (accept) begin
                    n_pos   = pos_x[AW-1:0];
                    n_val   = i_new_value;
                    n_state = iaid_pkg::S_REPLY;
                    case (i_op)
                        iaid_pkg::OP_INSERT: begin
                            if (pos_x > cnt_x) begin
                                n_res.status = iaid_pkg::ST_BADIDX;
                            end else if (cnt_x >= cap_x) begin
                                n_res.status = iaid_pkg::ST_FULL;
                            end else begin
                                n_idx   = r_count;
                                n_state = (cnt_x > pos_x) ? iaid_pkg::S_INS_RD
                                                          : iaid_pkg::S_INS_PUT;
                            end
                        end
                        iaid_pkg::OP_DELETE: begin
                            if (r_count == '0) begin
                                n_res.status = iaid_pkg::ST_EMPTY;
                            end else if (pos_x >= cnt_x) begin
                                n_res.status = iaid_pkg::ST_BADIDX;
                            end else begin
                                n_idx   = pos_x[CW-1:0];
                                n_state = iaid_pkg::S_DEL_RD0;
                            end
                        end
                        iaid_pkg::OP_TRAVERSE: begin
                            if (r_count == '0) begin
                                n_res.status = iaid_pkg::ST_EMPTY;
                            end else begin
                                n_idx   = '0;
                                n_state = iaid_pkg::S_TRV_RD;
                            end
                        end
                        default: begin
                            n_res.status = iaid_pkg::ST_BADIDX;
                        end
                    endcase
                end
            end

            // insert: move entry idx-1 up to idx, down to the target slot
            iaid_pkg::S_INS_RD: begin
                o_re    = 1'b1;
                o_raddr = idx_m1[AW-1:0];
                n_state = iaid_pkg::S_INS_WR;
            end
            iaid_pkg::S_INS_WR: begin
                o_we    = 1'b1;
                o_waddr = r_idx[AW-1:0];
                o_wdata = i_rdata;
                n_idx   = idx_m1;
                n_state = (idx_m1 != CW'(r_pos)) ? iaid_pkg::S_INS_RD
                                                 : iaid_pkg::S_INS_PUT;
            end
            iaid_pkg::S_INS_PUT: begin
                o_we           = 1'b1;
                o_waddr        = r_pos;
                o_wdata        = r_val;
                n_count        = r_count + CW'(1);
                n_res.status   = iaid_pkg::ST_OK;
                n_res.value    = r_val;
                n_res.position = iaid_pkg::IPOS_W'(XW'(r_pos));
                n_res.count    = iaid_pkg::CNT_W'(XW'(r_count + CW'(1)));
                n_res.last     = 1'b1;
                n_state        = iaid_pkg::S_REPLY;
            end

            // delete: capture the removed value, then pull later entries down
            iaid_pkg::S_DEL_RD0: begin
                o_re    = 1'b1;
                o_raddr = r_idx[AW-1:0];
                n_state = iaid_pkg::S_DEL_CAP;
            end
            iaid_pkg::S_DEL_CAP: begin
                n_val   = i_rdata;
                n_state = (idx_p1 < r_count) ? iaid_pkg::S_DEL_RD : iaid_pkg::S_REPLY;
                if (idx_p1 >= r_count) begin
                    n_count        = r_count - CW'(1);
                    n_res.status   = iaid_pkg::ST_OK;
                    n_res.value    = i_rdata;
                    n_res.position = iaid_pkg::IPOS_W'(XW'(r_pos));
                    n_res.count    = iaid_pkg::CNT_W'(XW'(r_count - CW'(1)));
                    n_res.last     = 1'b1;
                end
            end
            iaid_pkg::S_DEL_RD: begin
                o_re    = 1'b1;
                o_raddr = idx_p1[AW-1:0];
                n_state = iaid_pkg::S_DEL_WR;
            end
            iaid_pkg::S_DEL_WR: begin
                o_we    = 1'b1;
                o_waddr = r_idx[AW-1:0];
                o_wdata = i_rdata;
                n_idx   = idx_p1;
                if (idx_p2 < r_count) begin
                    n_state = iaid_pkg::S_DEL_RD;
                end else begin
                    n_count        = r_count - CW'(1);
                    n_res.status   = iaid_pkg::ST_OK;
                    n_res.value    = r_val;
                    n_res.position = iaid_pkg::IPOS_W'(XW'(r_pos));
                    n_res.count    = iaid_pkg::CNT_W'(XW'(r_count - CW'(1)));
                    n_res.last     = 1'b1;
                    n_state        = iaid_pkg::S_REPLY;
                end
            end

            // traverse: one read, then one result per element
            iaid_pkg::S_TRV_RD: begin
                o_re    = 1'b1;
                o_raddr = r_idx[AW-1:0];
                n_state = iaid_pkg::S_TRV_PUT;
            end
            iaid_pkg::S_TRV_PUT: begin
                o_res_valid    = 1'b1;
                o_res.status   = iaid_pkg::ST_OK;
                o_res.value    = i_rdata;
                o_res.position = idx_x[iaid_pkg::IPOS_W-1:0];
                o_res.count    = cnt_x[iaid_pkg::CNT_W-1:0];
                o_res.last     = (idx_p1 == r_count);
                if (i_res_ready) begin
                    n_idx   = idx_p1;
                    n_state = (idx_p1 == r_count) ? iaid_pkg::S_IDLE
                                                  : iaid_pkg::S_TRV_RD;
                end
            end

            iaid_pkg::S_REPLY: begin
                o_res_valid = 1'b1;
                if (i_res_ready) begin
                    n_state = iaid_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = iaid_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= iaid_pkg::S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        r_pos <= n_pos;
        r_val <= n_val;
        r_res <= n_res;
    end

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the indexed array insert/delete core.
// A shadow copy of the element array and count predicts every result of
// each request at the moment the request transfers. A monitor compares each
// result transfer field by field with the oldest prediction. Directed tests
// cover the empty, full and bad-index cases and the value extremes. A
// back-pressure test backs the core up. Random traffic then walks
// the count between empty and full under several idle and stall mixes.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int unsigned CAPACITY     = 64;
    localparam int unsigned DRAIN_CYCLES = 2 * CAPACITY + 16;   // worst request latency plus margin
    localparam int unsigned CYCLE_LIMIT  = 2_000_000;
    localparam int unsigned MAX_REPORTS  = 10;
    localparam logic [1:0]  OP_UNUSED    = 2'd3;   // undefined code, answered as a bad index

    // ------------------------------------------------------------------------
    // DUT signals; every input has a known value from time zero
    // ------------------------------------------------------------------------
    logic                               i_clk;
    logic                               i_rst_n     = 1'b0;
    logic                               i_valid     = 1'b0;
    logic                               o_ready;
    logic [1:0]                         i_op        = iaid_pkg::OP_INSERT;
    logic [iaid_pkg::POS_W-1:0]         i_position  = '0;
    logic signed [iaid_pkg::DATA_W-1:0] i_new_value = '0;
    logic                               o_valid;
    logic                               i_ready     = 1'b0;
    logic [1:0]                         o_status;
    logic signed [iaid_pkg::DATA_W-1:0] o_item_value;
    logic [iaid_pkg::IPOS_W-1:0]        o_item_position;
    logic [iaid_pkg::CNT_W-1:0]         o_new_count;
    logic                               o_last;

    indexed_array_insert_delete_core #(
        .CAPACITY (CAPACITY)
    ) i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_op            (i_op),
        .i_position      (i_position),
        .i_new_value     (i_new_value),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_status        (o_status),
        .o_item_value    (o_item_value),
        .o_item_position (o_item_position),
        .o_new_count     (o_new_count),
        .o_last          (o_last)
    );

    // ------------------------------------------------------------------------
    // Shadow state and pending results
    // ------------------------------------------------------------------------
    logic signed [iaid_pkg::DATA_W-1:0] shadow_elems [CAPACITY];
    int unsigned                        shadow_count = 0;
    iaid_pkg::t_result                  pending_results [$];

    int unsigned error_count   = 0;
    int unsigned send_idle_pct = 0;   // chance per cycle that the sender holds off
    int unsigned rx_stall_pct  = 0;   // chance per cycle that the receiver stalls
    int unsigned rx_hold_len   = 0;   // request for one long receiver hold-off
    logic        rx_hold       = 1'b0;
    int unsigned cycle_count   = 0;

    // 125 MHz clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Run limit: a hang anywhere ends here.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Some tests failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Error reporting: the first few in full, the rest only counted
    // ------------------------------------------------------------------------
    task automatic flag_error(input string msg);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("[%0t] ERROR: %s", $realtime, msg);
    endtask

    function automatic void queue_result(input logic [1:0] st,
                                         input logic signed [iaid_pkg::DATA_W-1:0] v,
                                         input int unsigned p, input int unsigned c,
                                         input logic l);
        iaid_pkg::t_result r;
        r.status   = st;
        r.value    = v;
        r.position = p[iaid_pkg::IPOS_W-1:0];
        r.count    = c[iaid_pkg::CNT_W-1:0];
        r.last     = l;
        pending_results.push_back(r);
    endfunction

    // ------------------------------------------------------------------------
    // Predictor: applies one request to the shadow array and queues what the
    // core must answer. Failed requests leave the array untouched and report
    // a zero value and index with the unchanged count.
    // ------------------------------------------------------------------------
    task automatic apply_array_request(input logic [1:0] op,
                                       input logic [iaid_pkg::POS_W-1:0] pos,
                                       input logic signed [iaid_pkg::DATA_W-1:0] val);
        int unsigned n;
        logic signed [iaid_pkg::DATA_W-1:0] removed;
        n = shadow_count;
        case (op)
            iaid_pkg::OP_INSERT: begin
                // the index is checked before fullness
                if (pos > n)
                    queue_result(iaid_pkg::ST_BADIDX, '0, 0, n, 1'b1);
                else if (n >= CAPACITY)
                    queue_result(iaid_pkg::ST_FULL, '0, 0, n, 1'b1);
                else begin
                    for (int i = n; i > pos; i--)
                        shadow_elems[i] = shadow_elems[i-1];
                    shadow_elems[pos] = val;
                    shadow_count = n + 1;
                    queue_result(iaid_pkg::ST_OK, val, pos, n + 1, 1'b1);
                end
            end
            iaid_pkg::OP_DELETE: begin
                // emptiness is checked before the index
                if (n == 0)
                    queue_result(iaid_pkg::ST_EMPTY, '0, 0, n, 1'b1);
                else if (pos >= n)
                    queue_result(iaid_pkg::ST_BADIDX, '0, 0, n, 1'b1);
                else begin
                    removed = shadow_elems[pos];
                    for (int i = pos; i + 1 < n; i++)
                        shadow_elems[i] = shadow_elems[i+1];
                    shadow_count = n - 1;
                    queue_result(iaid_pkg::ST_OK, removed, pos, n - 1, 1'b1);
                end
            end
            iaid_pkg::OP_TRAVERSE: begin
                if (n == 0)
                    queue_result(iaid_pkg::ST_EMPTY, '0, 0, n, 1'b1);
                else
                    for (int i = 0; i < n; i++)
                        queue_result(iaid_pkg::ST_OK, shadow_elems[i], i, n, (i + 1 == n));
            end
            default: queue_result(iaid_pkg::ST_BADIDX, '0, 0, n, 1'b1);
        endcase
    endtask

    // ------------------------------------------------------------------------
    // Request driver. Called at a rising edge; returns at the edge of the
    // transfer with valid still high, so back-to-back requests never drop it.
    // ------------------------------------------------------------------------
    task automatic send_request(input logic [1:0] op, input logic [iaid_pkg::POS_W-1:0] pos,
                                input logic signed [iaid_pkg::DATA_W-1:0] val);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < send_idle_pct);
        end
        i_valid     <= 1'b1;
        i_op        <= op;
        i_position  <= pos;
        i_new_value <= val;
        do @(posedge i_clk); while (!o_ready);
        apply_array_request(op, pos, val);
    endtask

    // Waits for every predicted result to arrive, then for the worst request
    // latency so nothing is still in flight.
    task automatic wait_results_drained();
        i_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic signed [iaid_pkg::DATA_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7FFF_FFFF;
            2:       return '0;
            3:       return -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Receiver and result monitor. Values are sampled before this edge's
    // updates, so the check sees exactly what the transfer carried.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        iaid_pkg::t_result want;
        i_ready <= !rx_hold && ($urandom_range(0, 99) >= rx_stall_pct);
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_results.size() == 0)
                flag_error($sformatf("result with none pending: st=%0d val=%0d pos=%0d cnt=%0d",
                                     o_status, o_item_value, o_item_position, o_new_count));
            else begin
                want = pending_results.pop_front();
                if (o_status !== want.status)
                    flag_error($sformatf("status exp %0d got %0d", want.status, o_status));
                if (o_item_value !== want.value)
                    flag_error($sformatf("item_value exp %0d got %0d", want.value, o_item_value));
                if (o_item_position !== want.position)
                    flag_error($sformatf("item_position exp %0d got %0d",
                                         want.position, o_item_position));
                if (o_new_count !== want.count)
                    flag_error($sformatf("new_count exp %0d got %0d", want.count, o_new_count));
                if (o_last !== want.last)
                    flag_error($sformatf("last exp %0d got %0d", want.last, o_last));
            end
        end
    end

    // One long receiver hold-off, timed here so the sender keeps offering.
    initial begin
        forever begin
            @(posedge i_clk);
            if (rx_hold_len > 0) begin
                rx_hold <= 1'b1;
                repeat (rx_hold_len) @(posedge i_clk);
                rx_hold <= 1'b0;
                rx_hold_len = 0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Every request on an empty array, plus the undefined op code.
    task automatic test_empty_array();
        send_request(iaid_pkg::OP_TRAVERSE, 7'd0,   32'sd5);
        send_request(iaid_pkg::OP_DELETE,   7'd0,   32'sd0);
        send_request(iaid_pkg::OP_DELETE,   7'd127, -32'sd1);    // empty wins over bad index
        send_request(iaid_pkg::OP_INSERT,   7'd1,   32'sd9);     // beyond count
        send_request(iaid_pkg::OP_INSERT,   7'd127, 32'sh7FFF_FFFF);
        send_request(OP_UNUSED,             7'd127, -32'sd1);
        send_request(OP_UNUSED,             7'd0,   32'sd0);
        wait_results_drained();
    endtask

    // Value extremes, inserts at head/middle/tail, bad deletes, shifting deletes.
    task automatic test_basic_ops();
        send_request(iaid_pkg::OP_INSERT,   7'd0,   32'sh8000_0000);
        send_request(iaid_pkg::OP_INSERT,   7'd1,   32'sh7FFF_FFFF);
        send_request(iaid_pkg::OP_INSERT,   7'd0,   -32'sd1);
        send_request(iaid_pkg::OP_INSERT,   7'd2,   32'sd0);
        send_request(iaid_pkg::OP_INSERT,   7'd4,   32'sh5A5A_A5A5);   // append at count
        send_request(iaid_pkg::OP_TRAVERSE, 7'd127, 32'sd0);
        send_request(iaid_pkg::OP_DELETE,   7'd5,   32'sd0);           // index equals count
        send_request(iaid_pkg::OP_DELETE,   7'd127, 32'sd0);
        send_request(iaid_pkg::OP_DELETE,   7'd2,   32'sd0);
        send_request(iaid_pkg::OP_DELETE,   7'd0,   32'sd0);
        send_request(iaid_pkg::OP_DELETE,   7'd2,   32'sd0);           // last element
        send_request(iaid_pkg::OP_TRAVERSE, 7'd0,   32'sd0);
        wait_results_drained();
    endtask

    // Fill to capacity, then the full-array cases and full-length shifts.
    task automatic test_fill_to_capacity();
        send_idle_pct = 14;
        rx_stall_pct  = 14;
        while (shadow_count < CAPACITY)
            send_request(iaid_pkg::OP_INSERT,
                         iaid_pkg::POS_W'($urandom_range(0, shadow_count)), pick_value());
        send_request(iaid_pkg::OP_INSERT,   7'd64,  32'sd1);   // valid index, array full
        send_request(iaid_pkg::OP_INSERT,   7'd0,   32'sd2);
        send_request(iaid_pkg::OP_INSERT,   7'd65,  32'sd3);   // bad index beats full
        send_request(iaid_pkg::OP_TRAVERSE, 7'd0,   32'sd0);
        send_request(iaid_pkg::OP_DELETE,   7'd63,  32'sd0);
        send_request(iaid_pkg::OP_DELETE,   7'd0,   32'sd0);   // longest shift down
        send_request(iaid_pkg::OP_INSERT,   7'd0,   pick_value());   // longest shift up
        send_request(iaid_pkg::OP_INSERT,   7'd63,  pick_value());
        send_request(iaid_pkg::OP_TRAVERSE, 7'd0,   32'sd0);
        wait_results_drained();
    endtask

    // Receiver holds off long enough for the core to back up its request side.
    task automatic test_output_backpressure();
        send_idle_pct = 0;
        rx_stall_pct  = 0;
        rx_hold_len   = 400;
        send_request(iaid_pkg::OP_TRAVERSE, 7'd0, 32'sd0);
        repeat (6) begin
            send_request(iaid_pkg::OP_DELETE,
                         iaid_pkg::POS_W'($urandom_range(0, shadow_count - 1)), 32'sd0);
            send_request(iaid_pkg::OP_INSERT,
                         iaid_pkg::POS_W'($urandom_range(0, shadow_count)), pick_value());
        end
        send_request(iaid_pkg::OP_TRAVERSE, 7'd0, 32'sd0);
        wait_results_drained();
    endtask

    // Mostly well-formed inserts and deletes that sweep the count between
    // empty and full, with traversals, bad indexes and the undefined code mixed in.
    task automatic test_random_traffic(input int unsigned idle_pct, input int unsigned stall_pct,
                                       input int unsigned n_items);
        bit growing;
        int unsigned pick;
        growing       = (shadow_count < CAPACITY / 2);
        send_idle_pct = idle_pct;
        rx_stall_pct  = stall_pct;
        repeat (n_items) begin
            if (shadow_count == CAPACITY) growing = 1'b0;
            if (shadow_count == 0)        growing = 1'b1;
            pick = $urandom_range(0, 99);
            if (pick < 6)
                send_request(iaid_pkg::OP_TRAVERSE, iaid_pkg::POS_W'($urandom), $urandom);
            else if (pick < 9)
                send_request(OP_UNUSED, iaid_pkg::POS_W'($urandom), $urandom);
            else if (pick < 12)
                send_request(iaid_pkg::OP_INSERT,
                             iaid_pkg::POS_W'($urandom_range(shadow_count + 1, 127)),
                             pick_value());
            else if (pick < 15)
                send_request(iaid_pkg::OP_DELETE,
                             iaid_pkg::POS_W'($urandom_range(shadow_count, 127)), $urandom);
            else if (($urandom_range(0, 99) < 75) == growing)
                send_request(iaid_pkg::OP_INSERT,
                             iaid_pkg::POS_W'($urandom_range(0, shadow_count)), pick_value());
            else if (shadow_count == 0)
                send_request(iaid_pkg::OP_DELETE, iaid_pkg::POS_W'($urandom), $urandom);
            else
                send_request(iaid_pkg::OP_DELETE,
                             iaid_pkg::POS_W'($urandom_range(0, shadow_count - 1)), $urandom);
        end
        wait_results_drained();
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_array();
        test_basic_ops();
        test_fill_to_capacity();
        test_output_backpressure();
        test_random_traffic(0,  0,  75);
        test_random_traffic(47, 0,  75);
        test_random_traffic(0,  47, 75);
        test_random_traffic(14, 14, 75);

        if (pending_results.size() != 0)
            flag_error($sformatf("%0d results never arrived", pending_results.size()));
        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/iaid_pkg.sv
rtl/iaid_store.sv
rtl/iaid_ctrl.sv
rtl/indexed_array_insert_delete_core.sv
sim/tb_top.sv
